@@ design/fml_pkg.sv @@
// ----------------------------------------------------------------------------
// fml_pkg: shared types and constants of the flowgram max-likelihood caller
// Holds state machine types, register indexes and fixed datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package fml_pkg;

    // widths fixed by the field formats
    localparam int FLOW_W = 14;   // flow intensity
    localparam int CFG_W  = 16;   // widest register
    localparam int K_W    = 12;   // candidate length, covers 2*round(x)+2
    localparam int X_W    = 32;   // flow in Q16
    localparam int DIFF_W = 28;   // |x - k| in Q16
    localparam int LN_W   = 24;   // natural log in Q16, signed
    localparam int Q_W    = 64;   // quadratic term and costs
    localparam int LEN_W  = 8;    // reported length

    // ln(2) in Q16 and the lognormal offset 0.005 in Q16
    localparam logic [15:0] LN2_Q16    = 16'd45426;
    localparam logic [15:0] OFFSET_Q16 = 16'd328;

    // register indexes
    typedef enum logic [2:0] {
        CFG_MU     = 3'd0,
        CFG_LSIG   = 3'd1,
        CFG_SIG1   = 3'd2,
        CFG_SIG2   = 3'd3,
        CFG_SIG3   = 3'd4,
        CFG_SIG4   = 3'd5,
        CFG_SIG5   = 3'd6,
        CFG_SCOUNT = 3'd7
    } t_cfg_idx;

    // log unit sequencer
    typedef enum logic [1:0] {
        LN_IDLE,
        LN_LOOP,
        LN_MUL,
        LN_DONE
    } t_ln_state;

    // quadratic term unit sequencer
    typedef enum logic [1:0] {
        QD_IDLE,
        QD_MUL,
        QD_DIV,
        QD_DONE
    } t_qd_state;

    // main sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LN_Y,
        ST_LN_SIG,
        ST_QUAD,
        ST_RESOLVE,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

@@ design/fml_ln_unit.sv @@
// ----------------------------------------------------------------------------
// fml_ln_unit: iterative natural log in Q16
// Leading-one normalize, 16 squaring steps for the log2 fraction, then ln2.
// ----------------------------------------------------------------------------
`default_nettype none

module fml_ln_unit (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_start,
    input  wire  [fml_pkg::X_W-1:0]           i_arg,
    output logic                              o_done,
    output logic signed [fml_pkg::LN_W-1:0]   o_result
);
    import fml_pkg::*;

    t_ln_state r_state, n_state;

    logic [30:0]          r_m;
    logic [4:0]           r_p;
    logic [15:0]          r_frac;
    logic [3:0]           r_i;
    logic signed [38:0]   r_prod;

    logic [X_W-1:0]       u;
    logic [4:0]           p;
    logic [X_W-1:0]       norm;
    logic [61:0]          sq;
    logic [31:0]          t;
    logic signed [21:0]   l2;
    logic signed [38:0]   rnd;

    // leading-one position and mantissa normalized to bit 30
    always_comb begin
        u = (i_arg == '0) ? X_W'(1) : i_arg;
        p = '0;
        for (int b = 0; b < X_W; b++) begin
            if (u[b]) p = 5'(b);
        end
        norm = u << (5'd31 - p);
    end

    // one squaring step per cycle
    assign sq = 62'(r_m) * 62'(r_m);
    assign t  = sq[61:30];
    assign l2 = $signed({6'(r_p) - 6'd16, r_frac});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            LN_IDLE: if (i_start) n_state = LN_LOOP;
            LN_LOOP: if (r_i == 4'd0) n_state = LN_MUL;
            LN_MUL:  n_state = LN_DONE;
            LN_DONE: n_state = LN_IDLE;
            default: n_state = LN_IDLE;
        endcase
    end

    // outputs: scale by ln2, truncate toward zero
    always_comb begin
        rnd      = (r_prod < 0) ? (r_prod + 39'sd65535) : r_prod;
        o_result = LN_W'(rnd >>> 16);
        o_done   = 1'b0;
        case (r_state)
            LN_DONE: o_done = 1'b1;
            default: o_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            LN_IDLE: begin
                r_m    <= norm[31:1];
                r_p    <= p;
                r_frac <= '0;
                r_i    <= 4'd15;
            end
            LN_LOOP: begin
                r_frac[r_i] <= t[31];
                r_m         <= t[31] ? t[31:1] : t[30:0];
                r_i         <= r_i - 4'd1;
            end
            LN_MUL: begin
                r_prod <= 39'(l2) * $signed({1'b0, LN2_Q16});
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/fml_quad_unit.sv @@
// ----------------------------------------------------------------------------
// fml_quad_unit: quadratic cost term (d^2 << 8) / (2 s^2)
// Squares in the multiply state, then a restoring divider retiring one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fml_quad_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [fml_pkg::DIFF_W-1:0]   i_diff,
    input  wire  [fml_pkg::CFG_W-1:0]    i_sig,
    output logic                         o_done,
    output logic [fml_pkg::Q_W-1:0]      o_result
);
    import fml_pkg::*;

    t_qd_state r_state, n_state;

    logic [DIFF_W-1:0]  r_diff;
    logic [CFG_W-1:0]   r_sig;
    logic [Q_W-1:0]     r_num;
    logic [32:0]        r_den;
    logic [32:0]        r_rem;
    logic [5:0]         r_cnt;

    logic [33:0]        rem_sh;
    logic               ge;

    assign rem_sh = {r_rem, r_num[Q_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            QD_IDLE: if (i_start) n_state = QD_MUL;
            QD_MUL:  n_state = QD_DIV;
            QD_DIV:  if (r_cnt == 6'd0) n_state = QD_DONE;
            QD_DONE: n_state = QD_IDLE;
            default: n_state = QD_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_result = r_num;
        case (r_state)
            QD_DONE: o_done = 1'b1;
            default: o_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= QD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath, quotient shifts in where the dividend shifts out
    always_ff @(posedge i_clk) begin
        case (r_state)
            QD_IDLE: begin
                r_diff <= i_diff;
                r_sig  <= i_sig;
            end
            QD_MUL: begin
                r_num <= {56'(r_diff) * 56'(r_diff), 8'b0};
                r_den <= {32'(r_sig) * 32'(r_sig), 1'b0};
                r_rem <= '0;
                r_cnt <= 6'd63;
            end
            QD_DIV: begin
                r_rem <= ge ? 33'(rem_sh - {1'b0, r_den}) : 33'(rem_sh);
                r_num <= {r_num[Q_W-2:0], ge};
                r_cnt <= r_cnt - 6'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/flowgram_max_likelihood_caller_unit.sv @@
// ----------------------------------------------------------------------------
// flowgram_max_likelihood_caller_unit: homopolymer length caller
// Per flow: a log of y, a log for each new spread, a quadratic term for each
// of the M + 1 candidates (M = 2*round(x)+2), then one result per beat.
// The quadratic-term divider dominates. One flow at a time; input not ready
// from accept until the last result beat, or until resolve if none is made.
// Synchronous active-low reset restores register defaults, clears held calls.
// ----------------------------------------------------------------------------
`default_nettype none

module flowgram_max_likelihood_caller_unit #(
    parameter int FLOW_FRAC_BITS = 8,
    parameter int MAX_FLOW_INT   = 63
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration write port
    input  wire                          i_cfg_we,
    input  wire  [2:0]                   i_cfg_index,
    input  wire  [fml_pkg::CFG_W-1:0]    i_cfg_wdata,
    // flow input
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [15:0]                  s_axis_tdata,   // [13:0] flow_value
    input  wire                          s_axis_tlast,   // flow_last
    // call output
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [7:0]                   m_axis_tdata,   // [7:0] call_length
    output logic                         m_axis_tlast    // read_end
);
    import fml_pkg::*;

    localparam logic [31:0]       FLOW_SAT = 32'(((MAX_FLOW_INT + 1) << FLOW_FRAC_BITS) - 1);
    localparam logic [FLOW_W:0]   HALF     = (FLOW_W + 1)'(1 << (FLOW_FRAC_BITS - 1));
    localparam logic [FLOW_W-1:0] ONE      = FLOW_W'(1 << FLOW_FRAC_BITS);

    // configuration registers
    logic signed [CFG_W-1:0] r_mu;
    logic [CFG_W-1:0]        r_lsig;
    logic [CFG_W-1:0]        r_sig [5];
    logic [2:0]              r_scount;

    // sequencer and item registers
    t_state r_state, n_state;
    logic [FLOW_W-1:0]       r_v;
    logic                    r_last;
    logic [X_W-1:0]          r_x;
    logic [K_W-1:0]          r_mx;
    logic [K_W-1:0]          r_k;
    logic signed [LN_W-1:0]  r_ly;
    logic signed [LN_W-1:0]  r_lns;
    logic signed [Q_W-1:0]   r_best;
    logic [K_W-1:0]          r_bestk;
    logic                    r_issued;

    // held zero calls
    logic [FLOW_W-1:0]       r_h0, r_h1;
    logic [1:0]              r_hc;

    // result queue
    logic [LEN_W-1:0]        r_q_len [3];
    logic                    r_q_end [3];
    logic [1:0]              r_q_cnt;
    logic [1:0]              r_q_idx;

    // item capture
    logic [FLOW_W-1:0]       v_in;
    logic [FLOW_W:0]         rnd_sum;
    logic [K_W-1:0]          rnd;
    logic                    accept;

    // candidate selection
    logic [2:0]              scnt;
    logic [2:0]              sidx;
    logic [CFG_W-1:0]        sig_raw;
    logic [CFG_W-1:0]        sig;
    logic [CFG_W-1:0]        lsig;
    logic signed [LN_W:0]    dlog;
    logic [DIFF_W-1:0]       kq;
    logic [DIFF_W-1:0]       x28;
    logic [DIFF_W-1:0]       diff;
    logic [X_W-1:0]          ln_arg;
    logic                    ln_start, ln_done;
    logic signed [LN_W-1:0]  ln_res;
    logic                    qd_start, qd_done;
    logic [Q_W-1:0]          qd_res;
    logic signed [Q_W-1:0]   cost;
    logic                    last_k;
    logic                    new_sig;

    // resolve
    logic [LEN_W-1:0]        n_q_len [3];
    logic                    n_q_end [3];
    logic [1:0]              n_q_cnt;
    logic [FLOW_W-1:0]       n_h0, n_h1;
    logic [1:0]              n_hc;
    logic [FLOW_W-1:0]       vals [3];
    logic [FLOW_W-1:0]       dd;
    logic [FLOW_W-1:0]       bd;
    logic [1:0]              wh;
    logic [LEN_W-1:0]        bestk_sat;

    // input saturation and candidate range
    always_comb begin
        v_in    = (32'(s_axis_tdata[13:0]) > FLOW_SAT) ? FLOW_SAT[FLOW_W-1:0]
                                                       : s_axis_tdata[13:0];
        rnd_sum = (FLOW_W + 1)'(v_in) + HALF;
        rnd     = K_W'(rnd_sum >> FLOW_FRAC_BITS);
        accept  = s_axis_tvalid && s_axis_tready;
    end

    // spread for the current candidate
    always_comb begin
        scnt    = (r_scount == 3'd0) ? 3'd1 : ((r_scount > 3'd5) ? 3'd5 : r_scount);
        sidx    = (r_k < K_W'(scnt)) ? 3'(r_k - K_W'(1)) : scnt - 3'd1;
        sig_raw = r_sig[sidx];
        lsig    = (r_lsig == '0) ? CFG_W'(1) : r_lsig;
        if (r_k == '0) begin
            sig = lsig;
        end else begin
            sig = (sig_raw == '0) ? CFG_W'(1) : sig_raw;
        end
    end

    // distance to the candidate
    always_comb begin
        dlog = (LN_W + 1)'(r_ly) - (LN_W + 1)'($signed({r_mu, 4'b0}));
        kq   = {r_k, 16'b0};
        x28  = r_x[DIFF_W-1:0];
        if (r_k == '0) begin
            diff = DIFF_W'((dlog < 0) ? -dlog : dlog);
        end else begin
            diff = (x28 > kq) ? (x28 - kq) : (kq - x28);
        end
        ln_arg  = (r_state == ST_LN_Y) ? (r_x + X_W'(OFFSET_Q16))
                                       : X_W'({sig, 4'b0});
        cost    = ((r_k == '0) ? Q_W'(r_ly) : '0) + Q_W'(r_lns) + $signed(qd_res);
        last_k  = (r_k == r_mx);
        new_sig = (r_k + K_W'(1)) <= K_W'(scnt);
    end

    fml_ln_unit u_ln (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ln_start),
        .i_arg    (ln_arg),
        .o_done   (ln_done),
        .o_result (ln_res)
    );

    fml_quad_unit u_quad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (qd_start),
        .i_diff   (diff),
        .i_sig    (sig),
        .o_done   (qd_done),
        .o_result (qd_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (s_axis_tvalid) n_state = ST_LN_Y;
            ST_LN_Y:    if (ln_done) n_state = ST_LN_SIG;
            ST_LN_SIG:  if (ln_done) n_state = ST_QUAD;
            ST_QUAD: begin
                if (qd_done) begin
                    if (last_k)       n_state = ST_RESOLVE;
                    else if (new_sig) n_state = ST_LN_SIG;
                    else              n_state = ST_QUAD;
                end
            end
            ST_RESOLVE: n_state = (n_q_cnt != 2'd0) ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (m_axis_tready && (r_q_idx == r_q_cnt - 2'd1)) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        ln_start      = 1'b0;
        qd_start      = 1'b0;
        m_axis_tdata  = r_q_len[r_q_idx];
        m_axis_tlast  = r_q_end[r_q_idx];
        case (r_state)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_LN_Y:   ln_start      = !r_issued;
            ST_LN_SIG: ln_start      = !r_issued;
            ST_QUAD:   qd_start      = !r_issued;
            ST_EMIT:   m_axis_tvalid = 1'b1;
            default: begin
            end
        endcase
    end

    // held-call resolution and result list
    always_comb begin
        n_q_cnt = '0;
        n_h0    = r_h0;
        n_h1    = r_h1;
        n_hc    = r_hc;
        wh      = '0;
        bd      = '1;
        dd      = '0;
        vals[0] = r_h0;
        vals[1] = r_h1;
        vals[2] = r_v;
        for (int i = 0; i < 3; i++) begin
            n_q_len[i] = '0;
            n_q_end[i] = 1'b0;
        end
        bestk_sat = (r_bestk > K_W'(255)) ? LEN_W'(255) : LEN_W'(r_bestk);
        if (r_bestk != '0) begin
            // flush held zeros ahead of the call
            for (int i = 0; i < 2; i++) begin
                if (2'(i) < r_hc) begin
                    n_q_len[n_q_cnt] = '0;
                    n_q_cnt          = n_q_cnt + 2'd1;
                end
            end
            n_q_len[n_q_cnt] = bestk_sat;
            n_q_cnt          = n_q_cnt + 2'd1;
            n_hc             = '0;
        end else if (r_hc == 2'd2) begin
            // third zero in a row: the one nearest 1 becomes a 1
            for (int i = 0; i < 3; i++) begin
                dd = (vals[i] > ONE) ? (vals[i] - ONE) : (ONE - vals[i]);
                if (dd < bd) begin
                    bd = dd;
                    wh = 2'(i);
                end
            end
            for (int i = 0; i < 2; i++) begin
                if (2'(i) < wh) begin
                    n_q_len[n_q_cnt] = '0;
                    n_q_cnt          = n_q_cnt + 2'd1;
                end
            end
            n_q_len[n_q_cnt] = LEN_W'(1);
            n_q_cnt          = n_q_cnt + 2'd1;
            case (wh)
                2'd0: begin
                    n_h0 = r_h1;
                    n_h1 = r_v;
                    n_hc = 2'd2;
                end
                2'd1: begin
                    n_h0 = r_v;
                    n_hc = 2'd1;
                end
                default: n_hc = 2'd0;
            endcase
        end else begin
            if (r_hc == 2'd0) n_h0 = r_v;
            else              n_h1 = r_v;
            n_hc = r_hc + 2'd1;
        end
        // end of read flushes what is still held
        if (r_last) begin
            for (int i = 0; i < 2; i++) begin
                if (2'(i) < n_hc) begin
                    n_q_len[n_q_cnt] = '0;
                    n_q_cnt          = n_q_cnt + 2'd1;
                end
            end
            n_hc = '0;
            if (n_q_cnt != 2'd0) n_q_end[n_q_cnt - 2'd1] = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
            r_hc     <= '0;
            r_q_cnt  <= '0;
            r_q_idx  <= '0;
            r_mu     <= '0;
            r_lsig   <= 16'd4096;
            for (int i = 0; i < 5; i++) r_sig[i] <= 16'd4096;
            r_scount <= 3'd1;
        end else begin
            r_state <= n_state;
            if (ln_start || qd_start)   r_issued <= 1'b1;
            else if (ln_done || qd_done) r_issued <= 1'b0;
            if (r_state == ST_RESOLVE) begin
                r_hc    <= n_hc;
                r_q_cnt <= n_q_cnt;
                r_q_idx <= '0;
            end
            if (m_axis_tvalid && m_axis_tready) r_q_idx <= r_q_idx + 2'd1;
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MU:     r_mu     <= i_cfg_wdata;
                    CFG_LSIG:   r_lsig   <= i_cfg_wdata;
                    CFG_SIG1:   r_sig[0] <= i_cfg_wdata;
                    CFG_SIG2:   r_sig[1] <= i_cfg_wdata;
                    CFG_SIG3:   r_sig[2] <= i_cfg_wdata;
                    CFG_SIG4:   r_sig[3] <= i_cfg_wdata;
                    CFG_SIG5:   r_sig[4] <= i_cfg_wdata;
                    CFG_SCOUNT: r_scount <= i_cfg_wdata[2:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_v    <= v_in;
            r_last <= s_axis_tlast;
            r_x    <= X_W'(v_in) << (16 - FLOW_FRAC_BITS);
            r_mx   <= K_W'({rnd, 1'b0}) + K_W'(2);
            r_k    <= '0;
        end
        if (r_state == ST_LN_Y && ln_done)   r_ly  <= ln_res;
        if (r_state == ST_LN_SIG && ln_done) r_lns <= ln_res;
        // keep the first minimum
        if (r_state == ST_QUAD && qd_done) begin
            if (r_k == '0 || cost < r_best) begin
                r_best  <= cost;
                r_bestk <= r_k;
            end
            if (!last_k) r_k <= r_k + K_W'(1);
        end
        if (r_state == ST_RESOLVE) begin
            r_h0 <= n_h0;
            r_h1 <= n_h1;
            for (int i = 0; i < 3; i++) begin
                r_q_len[i] <= n_q_len[i];
                r_q_end[i] <= n_q_end[i];
            end
        end
    end

    // checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while results pending");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_LN_Y))
        else $error("accepted flow did not start scoring");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hc != 2'd3)
        else $error("more than two zero calls held");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_q_cnt != 2'd0 && r_q_idx < r_q_cnt))
        else $error("result beat with empty queue");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QUAD) |-> (r_k <= r_mx))
        else $error("candidate beyond range");

endmodule

`default_nettype wire

@@ sim/flowgram_max_likelihood_caller_unit_tb.sv @@
// ----------------------------------------------------------------------------
// flowgram_max_likelihood_caller_unit_tb: self-checking bench of the caller
// Streams flow beats through the unit under several register settings and
// checks every call beat against a bit-accurate length predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flowgram_max_likelihood_caller_unit_tb;
    import fml_pkg::*;

    localparam int FRAC       = 8;
    localparam int WATCH_MAX  = 60000;
    localparam int LONG_HOLD  = 400;
    localparam int NO_CALL    = -1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [2:0]           i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;

    flowgram_max_likelihood_caller_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of the registers and held zero calls
    logic signed [15:0] mdl_mu;
    logic [15:0]        mdl_lsig;
    logic [15:0]        mdl_sig [5];
    logic [2:0]         mdl_count;
    logic [13:0]        held_flow [2];
    int                 held_n;

    logic [7:0]         want_len [$];
    logic               want_end [$];

    int errors = 0;
    int flows_in = 0;
    int calls_out = 0;
    int tx_idle = 0;
    int rx_idle = 0;
    bit rx_hold_start = 0;
    int rx_hold_left = 0;
    int quiet = 0;

    // natural log in Q16
    function automatic longint ln_q16(logic [63:0] u);
        int p;
        logic [63:0] m;
        longint frac;
        longint l2;
        frac = 0;
        if (u == 0) u = 1;
        p = 63;
        while (!u[p]) p--;
        if (p >= 30) m = u >> (p - 30);
        else m = u << (30 - p);
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                frac += longint'(1) << i;
                m = m >> 1;
            end
        end
        l2 = (longint'(p) - 16) * 65536 + frac;
        return (l2 * 45426) / 65536;
    endfunction

    function automatic logic [63:0] quad(logic [63:0] d, logic [15:0] s);
        logic [63:0] ss;
        ss = (s == 0) ? 64'd1 : {48'd0, s};
        return ((d * d) << 8) / (64'd2 * ss * ss);
    endfunction

    // most likely homopolymer length of one flow
    function automatic int call_of(logic [13:0] v);
        logic [63:0] x, y, ad, kq, dk;
        logic [15:0] sl, s;
        int rnd, mx, cnt, k, bestk;
        longint ly, d, best, c;
        x = {50'd0, v} << (16 - FRAC);
        rnd = (int'(v) + (1 << (FRAC - 1))) >> FRAC;
        mx = rnd * 2 + 2;
        cnt = (mdl_count == 0) ? 1 : ((mdl_count > 5) ? 5 : int'(mdl_count));
        sl = (mdl_lsig == 0) ? 16'd1 : mdl_lsig;
        y = x + 64'd328;
        ly = ln_q16(y);
        d = ly - longint'(mdl_mu) * 16;
        ad = (d < 0) ? 64'(-d) : 64'(d);
        best = ly + ln_q16({48'd0, sl} << 4) + longint'(quad(ad, sl));
        bestk = 0;
        for (k = 1; k <= mx; k++) begin
            s = mdl_sig[((k < cnt) ? k : cnt) - 1];
            if (s == 0) s = 1;
            kq = 64'(k) << 16;
            dk = (x > kq) ? x - kq : kq - x;
            c = ln_q16({48'd0, s} << 4) + longint'(quad(dk, s));
            if (c < best) begin
                best = c;
                bestk = k;
            end
        end
        return bestk;
    endfunction

    // expected call beats caused by one flow beat
    task automatic predict_calls(logic [13:0] v, logic last);
        int k, n, wh, bd, dd;
        int lens [3];
        logic [13:0] vals [3];
        n = 0;
        k = call_of(v);
        if (k != 0) begin
            for (int i = 0; i < held_n; i++) lens[n++] = 0;
            lens[n++] = (k > 255) ? 255 : k;
            held_n = 0;
        end else if (held_n == 2) begin
            // three zeros: the one nearest 1.0 becomes a 1
            vals[0] = held_flow[0];
            vals[1] = held_flow[1];
            vals[2] = v;
            wh = 0;
            bd = 32'h7fff_ffff;
            for (int i = 0; i < 3; i++) begin
                dd = int'(vals[i]) - (1 << FRAC);
                if (dd < 0) dd = -dd;
                if (dd < bd) begin
                    bd = dd;
                    wh = i;
                end
            end
            for (int i = 0; i < wh; i++) lens[n++] = 0;
            lens[n++] = 1;
            held_n = 0;
            for (int i = wh + 1; i < 3; i++) held_flow[held_n++] = vals[i];
        end else begin
            held_flow[held_n++] = v;
        end
        if (last) begin
            for (int i = 0; i < held_n; i++) lens[n++] = 0;
            held_n = 0;
        end
        for (int i = 0; i < n; i++) begin
            want_len.push_back(8'(lens[i]));
            want_end.push_back(last && (i == n - 1));
        end
    endtask

    // register write, predictor copy follows at the same edge
    task automatic cfg_write(t_cfg_idx idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_MU:     mdl_mu = val;
            CFG_LSIG:   mdl_lsig = val;
            CFG_SCOUNT: mdl_count = val[2:0];
            default:    mdl_sig[idx - CFG_SIG1] = val;
        endcase
    endtask

    task automatic cfg_all(logic [15:0] mu, logic [15:0] ls, logic [15:0] s1,
                           logic [15:0] s2, logic [15:0] s3, logic [15:0] s4,
                           logic [15:0] s5, logic [2:0] cnt);
        cfg_write(CFG_MU, mu);
        cfg_write(CFG_LSIG, ls);
        cfg_write(CFG_SIG1, s1);
        cfg_write(CFG_SIG2, s2);
        cfg_write(CFG_SIG3, s3);
        cfg_write(CFG_SIG4, s4);
        cfg_write(CFG_SIG5, s5);
        cfg_write(CFG_SCOUNT, {13'd0, cnt});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one flow beat and wait for it to be taken
    task automatic send_flow(logic [13:0] v, logic last);
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, v};
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering until every call is out and the unit is idle again
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (want_len.size() != 0) @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [13:0] rand_flow();
        int r;
        r = $urandom_range(99);
        if (r < 35) return 14'($urandom_range(0, 40));
        if (r < 75) return 14'(($urandom_range(1, 4) << FRAC) + $urandom_range(0, 80) - 40);
        if (r < 95) return 14'($urandom_range(0, 2047));
        return 14'($urandom_range(0, 16383));
    endfunction

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_flow(rand_flow(), $urandom_range(7) == 0);
    endtask

    // directed flows, typed call where obvious with spreads of 1.0
    typedef struct {
        logic [13:0] flow;
        logic        last;
        int          want;
    } t_row;

    t_row dflt_rows [10] = '{
        '{14'd256,   1'b1, 1},
        '{14'd512,   1'b1, 2},
        '{14'd16383, 1'b1, NO_CALL},
        '{14'd16320, 1'b1, NO_CALL},
        '{14'd0,     1'b0, NO_CALL},
        '{14'd1,     1'b0, NO_CALL},
        '{14'd128,   1'b0, NO_CALL},
        '{14'd383,   1'b0, NO_CALL},
        '{14'd384,   1'b0, NO_CALL},
        '{14'd10922, 1'b1, NO_CALL}
    };

    // zero-prone setting: runs of zeros, ties, flush on last
    t_row zero_rows [14] = '{
        '{14'd0,  1'b0, NO_CALL},
        '{14'd0,  1'b0, NO_CALL},
        '{14'd0,  1'b0, NO_CALL},
        '{14'd3,  1'b0, NO_CALL},
        '{14'd1,  1'b0, NO_CALL},
        '{14'd2,  1'b0, NO_CALL},
        '{14'd0,  1'b1, NO_CALL},
        '{14'd0,  1'b0, NO_CALL},
        '{14'd0,  1'b1, NO_CALL},
        '{14'd1,  1'b0, NO_CALL},
        '{14'd5,  1'b0, NO_CALL},
        '{14'd2,  1'b1, NO_CALL},
        '{14'd0,  1'b0, NO_CALL},
        '{14'd768, 1'b1, NO_CALL}
    };

    // sink ready, with one long hold-off on request
    always @(posedge i_clk) begin
        if (rx_hold_start) begin
            rx_hold_start = 0;
            rx_hold_left = LONG_HOLD;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // beat monitor, call checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet++;
            if (s_axis_tvalid && s_axis_tready) begin
                quiet = 0;
                flows_in++;
                predict_calls(s_axis_tdata[13:0], s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                quiet = 0;
                calls_out++;
                if (want_len.size() == 0) begin
                    $error("unexpected call beat: length %0d", m_axis_tdata);
                    errors++;
                end else begin
                    if (m_axis_tdata !== want_len[0]) begin
                        $error("call_length: expected %0d, got %0d",
                               want_len[0], m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tlast !== want_end[0]) begin
                        $error("read_end: expected %0d, got %0d",
                               want_end[0], m_axis_tlast);
                        errors++;
                    end
                    void'(want_len.pop_front());
                    void'(want_end.pop_front());
                end
            end
            if (quiet >= WATCH_MAX) begin
                $display("watchdog: no beat for %0d cycles", quiet);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        mdl_mu = 0;
        mdl_lsig = 16'd4096;
        for (int i = 0; i < 5; i++) mdl_sig[i] = 16'd4096;
        mdl_count = 3'd1;
        held_n = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed flows at reset settings
        tx_idle = 25;
        rx_idle = 50;
        foreach (dflt_rows[i]) begin
            send_flow(dflt_rows[i].flow, dflt_rows[i].last);
            s_axis_tvalid <= 1'b0;
            // let the monitor queue this beat before the typed call replaces it
            @(negedge i_clk);
            if (dflt_rows[i].want != NO_CALL) want_len[$] = 8'(dflt_rows[i].want);
            @(posedge i_clk);
        end
        drain();

        // zero-prone setting for the repair cases
        cfg_all(16'hab3c, 16'd12288, 16'd4096, 16'd6000, 16'd8192, 16'd9000,
                16'd10000, 3'd3);
        foreach (zero_rows[i]) send_flow(zero_rows[i].flow, zero_rows[i].last);
        drain();

        // extremes: lowest mu, widest lognormal, zero spreads, count 0
        cfg_all(16'h8000, 16'hffff, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 3'd0);
        send_random(45);
        drain();
        cfg_all(16'h7fff, 16'd1, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                16'hffff, 3'd7);
        send_random(45);
        drain();

        // swapped idling
        tx_idle = 50;
        rx_idle = 25;
        cfg_all(16'hab3c, 16'd12288, 16'd3000, 16'd5000, 16'd7000, 16'd9000,
                16'd11000, 3'd5);
        send_random(90);
        drain();

        // no idling, one long sink hold-off while the source keeps offering
        tx_idle = 0;
        rx_idle = 0;
        cfg_all(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)),
                16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                16'($urandom_range(1, 65535)), 3'($urandom_range(1, 5)));
        send_random(30);
        rx_hold_start = 1;
        send_random(60);
        drain();
        cfg_all(16'hb000, 16'd8192, 16'd4096, 16'd5000, 16'd6000, 16'd7000,
                16'd8000, 3'd2);
        send_random(90);
        drain();

        repeat (200) @(posedge i_clk);
        $display("covered %0d flow beats and %0d call beats over seven settings",
                 flows_in, calls_out);
        $display("settings include extreme, zero and out-of-range spread registers");
        if (errors == 0 && want_len.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/fml_pkg.sv
design/fml_ln_unit.sv
design/fml_quad_unit.sv
design/flowgram_max_likelihood_caller_unit.sv
sim/flowgram_max_likelihood_caller_unit_tb.sv
